/* rtl/utf8_byte_stream_decoder_macros.svh */
// ----------------------------------------------------------------------------
// utf8 byte stream decoder assertion macros
// shared concurrent assertion forms, clocked on aclk, held off in reset
// ----------------------------------------------------------------------------
`ifndef UTF8_BYTE_STREAM_DECODER_MACROS_SVH
`define UTF8_BYTE_STREAM_DECODER_MACROS_SVH

// same-cycle implication
`define U8DEC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("u8dec assertion failed");

// next-cycle implication
`define U8DEC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("u8dec assertion failed");

`endif

/* rtl/u8dec_pkg.sv */
// ----------------------------------------------------------------------------
// u8dec_pkg
// types and codes shared by the utf8 byte stream decoder modules
// ----------------------------------------------------------------------------
package u8dec_pkg;

    localparam int unsigned CP_W   = 31;
    localparam int unsigned LEFT_W = 3;

    // result status codes
    typedef enum logic [1:0] {
        ST_CHAR     = 2'd0,
        ST_EOS      = 2'd1,
        ST_BAD_LEAD = 2'd2,
        ST_NUL_SEQ  = 2'd3
    } status_t;

    // sequence state carried between beats
    typedef struct packed {
        logic [CP_W-1:0]   partial;
        logic [LEFT_W-1:0] left;
    } seq_state_t;

    // one result beat
    typedef struct packed {
        logic            emit;
        logic [CP_W-1:0] code_point;
        status_t         status;
    } result_t;

endpackage

/* rtl/utf8_byte_stream_decoder.sv */
// ----------------------------------------------------------------------------
// utf8_byte_stream_decoder
// decodes legacy 1 to 6 byte utf-8 sequences into 31-bit code points
// ----------------------------------------------------------------------------
//  channel | ports                                  | beat
//  --------+----------------------------------------+---------------------------
//  input   | s_valid s_ready s_in_byte              | one raw byte
//  result  | m_valid m_ready m_code_point m_status  | character or status report
//
//  one byte is taken every cycle while s_ready is high; any result is valid the next cycle
//  the decode is a single pass of mask, shift and or into the result register
//  s_ready drops only while a result waits and m_ready is low
//  aresetn (synchronous, active low) clears the sequence state and m_valid
// ----------------------------------------------------------------------------
`include "utf8_byte_stream_decoder_macros.svh"

module utf8_byte_stream_decoder
    import u8dec_pkg::*;
(
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  logic [7:0]      s_in_byte,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [CP_W-1:0] m_code_point,
    output logic [1:0]      m_status
);

    seq_state_t      state_reg, state_next;
    result_t         step_res;
    logic            m_valid_reg, m_valid_next;
    logic [CP_W-1:0] cp_reg;
    status_t         status_reg;
    logic            s_accept;
    logic            top_nul;

    // byte decode
    u8dec_step u_step (
        .in_byte    (s_in_byte),
        .state      (state_reg),
        .state_next (state_next),
        .result     (step_res)
    );

    // handshake
    assign s_ready  = !m_valid_reg || m_ready;
    assign s_accept = s_valid && s_ready;

    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        if (s_accept && step_res.emit) begin
            m_valid_next = 1'b1;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (s_accept) begin
                state_reg <= state_next;
            end
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (s_accept && step_res.emit) begin
            cp_reg     <= step_res.code_point;
            status_reg <= step_res.status;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_code_point = cp_reg;
    assign m_status     = status_reg;

    // nul byte arriving at top level
    assign top_nul = s_accept && state_reg.left == '0 && s_in_byte == 8'd0;

    // reports carry a zero code point
    `U8DEC_ASSERT_SAME(a_report_zero_cp, m_valid_reg && status_reg != ST_CHAR, cp_reg == '0)
    // nul at top level gives end of string next cycle
    `U8DEC_ASSERT_NEXT(a_eos_report, top_nul, m_valid_reg && status_reg == ST_EOS)
    // every result clears the sequence state
    `U8DEC_ASSERT_NEXT(a_emit_clears, s_accept && step_res.emit, state_reg == '0)
    // sequence length never exceeds five continuation bytes
    `U8DEC_ASSERT_SAME(a_left_range, s_accept, state_reg.left <= LEFT_W'(5))

endmodule

/* rtl/u8dec_step.sv */
// ----------------------------------------------------------------------------
// u8dec_step
// decodes one byte against the current sequence state: next state and result
// ----------------------------------------------------------------------------
module u8dec_step
    import u8dec_pkg::*;
(
    input  logic [7:0]  in_byte,
    input  seq_state_t  state,
    output seq_state_t  state_next,
    output result_t     result
);

    logic [CP_W-1:0] shifted;

    // continuation: append the low six bits
    assign shifted = {state.partial[CP_W-7:0], in_byte[5:0]};

    always_comb begin
        state_next        = state;
        result.emit       = 1'b0;
        result.code_point = '0;
        result.status     = ST_CHAR;

        if (state.left != '0) begin
            if (in_byte == 8'd0) begin
                // nul inside a sequence drops the partial value
                result.emit   = 1'b1;
                result.status = ST_NUL_SEQ;
                state_next    = '0;
            end else if (state.left == LEFT_W'(1)) begin
                // last continuation byte closes the character
                result.emit       = 1'b1;
                result.code_point = shifted;
                result.status     = ST_CHAR;
                state_next        = '0;
            end else begin
                state_next.partial = shifted;
                state_next.left    = state.left - LEFT_W'(1);
            end
        end else if (in_byte == 8'd0) begin
            // nul at top level ends the string
            result.emit   = 1'b1;
            result.status = ST_EOS;
        end else begin
            unique case (in_byte) inside
                8'b0???_????: begin
                    result.emit       = 1'b1;
                    result.code_point = CP_W'(in_byte);
                    result.status     = ST_CHAR;
                end
                8'b110?_????: begin
                    state_next.partial = CP_W'(in_byte[4:0]);
                    state_next.left    = LEFT_W'(1);
                end
                8'b1110_????: begin
                    state_next.partial = CP_W'(in_byte[3:0]);
                    state_next.left    = LEFT_W'(2);
                end
                8'b1111_0???: begin
                    state_next.partial = CP_W'(in_byte[2:0]);
                    state_next.left    = LEFT_W'(3);
                end
                8'b1111_10??: begin
                    state_next.partial = CP_W'(in_byte[1:0]);
                    state_next.left    = LEFT_W'(4);
                end
                8'b1111_110?: begin
                    state_next.partial = CP_W'(in_byte[0]);
                    state_next.left    = LEFT_W'(5);
                end
                default: begin
                    // stray continuation byte, 0xfe or 0xff
                    result.emit   = 1'b1;
                    result.status = ST_BAD_LEAD;
                    state_next    = '0;
                end
            endcase
        end
    end

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// utf8 byte stream decoder testbench
// feeds directed and random byte streams through the decoder, tracks the
// sequence state on the side and checks every character or status beat
// ----------------------------------------------------------------------------
module tb;
    import u8dec_pkg::*;

    localparam int unsigned RANDOM_BYTES   = 1680;
    localparam int unsigned CALM_TAIL      = 200;
    localparam int unsigned PAUSE_AT       = 800;
    localparam int unsigned PHASE_LEN      = 150;
    localparam int unsigned WATCHDOG_LIMIT = 500;
    localparam int unsigned DRAIN_CYCLES   = 8;

    // edge values, bad leads, overlong zero, nul inside, longest forms
    // the six byte form uses continuations without the 10 tag
    localparam logic [7:0] DIRECTED_BYTES [25] = '{
        8'h00, 8'h01, 8'h7F,
        8'h80, 8'hFE, 8'hFF,
        8'hC0, 8'h80,
        8'hE2, 8'h00,
        8'hF7, 8'hBF, 8'hBF, 8'hBF,
        8'hFB, 8'hBF, 8'hBF, 8'hBF, 8'hBF,
        8'hFD, 8'h3F, 8'h7F, 8'hFF, 8'hBF, 8'hBF
    };

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        status_t         status;
    } char_beat_t;

    // decoder shadow plus the queue of characters still owed by the block
    class decode_scoreboard;
        char_beat_t        pending_chars[$];
        logic [CP_W-1:0]   partial_cp;
        logic [LEFT_W-1:0] bytes_left;
        int unsigned       fail_count;

        function new();
            partial_cp = '0;
            bytes_left = '0;
            fail_count = 0;
        endfunction

        function int pending_count();
            return pending_chars.size();
        endfunction

        // advance the shadow decoder by one accepted byte
        function void note_byte(logic [7:0] b);
            char_beat_t beat;
            bit         has_char;
            has_char        = 1'b1;
            beat.code_point = '0;
            beat.status     = ST_CHAR;
            if (bytes_left != 0) begin
                if (b == 8'h00) begin
                    beat.status = ST_NUL_SEQ;
                end else begin
                    partial_cp = {partial_cp[CP_W-7:0], b[5:0]};
                    bytes_left = bytes_left - 1'b1;
                    if (bytes_left == 0) begin
                        beat.code_point = partial_cp;
                    end else begin
                        has_char = 1'b0;
                    end
                end
            end else if (b == 8'h00) begin
                beat.status = ST_EOS;
            end else if (b < 8'h80) begin
                beat.code_point = CP_W'(b);
            end else if (b >= 8'hC0 && b <= 8'hDF) begin
                partial_cp = CP_W'(b[4:0]);
                bytes_left = 3'd1;
                has_char   = 1'b0;
            end else if (b >= 8'hE0 && b <= 8'hEF) begin
                partial_cp = CP_W'(b[3:0]);
                bytes_left = 3'd2;
                has_char   = 1'b0;
            end else if (b >= 8'hF0 && b <= 8'hF7) begin
                partial_cp = CP_W'(b[2:0]);
                bytes_left = 3'd3;
                has_char   = 1'b0;
            end else if (b >= 8'hF8 && b <= 8'hFB) begin
                partial_cp = CP_W'(b[1:0]);
                bytes_left = 3'd4;
                has_char   = 1'b0;
            end else if (b >= 8'hFC && b <= 8'hFD) begin
                partial_cp = CP_W'(b[0]);
                bytes_left = 3'd5;
                has_char   = 1'b0;
            end else begin
                beat.status = ST_BAD_LEAD;
            end
            // any beat out clears the sequence
            if (has_char) begin
                partial_cp = '0;
                bytes_left = '0;
                pending_chars.push_back(beat);
            end
        endfunction

        task report_mismatch(string msg);
            $display("%0t mismatch: %s", $realtime, msg);
            fail_count++;
        endtask

        // compare one result beat against the oldest owed character
        task check_char(logic [CP_W-1:0] cp, logic [1:0] st);
            char_beat_t want;
            if (pending_chars.size() == 0) begin
                report_mismatch($sformatf("unexpected beat cp=%h status=%0d", cp, st));
                return;
            end
            want = pending_chars.pop_front();
            if (cp !== want.code_point)
                report_mismatch($sformatf("code_point %h, want %h", cp, want.code_point));
            if (st !== want.status)
                report_mismatch($sformatf("status %0d, want %0d", st, want.status));
        endtask
    endclass

    logic            aclk;
    logic            aresetn;
    logic            s_valid;
    logic            s_ready;
    logic [7:0]      s_in_byte;
    logic            m_valid;
    logic            m_ready;
    logic [CP_W-1:0] m_code_point;
    logic [1:0]      m_status;

    decode_scoreboard sb = new();
    int unsigned      bytes_sent;
    int unsigned      gap_pct;
    int unsigned      stall_pct;

    utf8_byte_stream_decoder dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_in_byte    (s_in_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_code_point (m_code_point),
        .m_status     (m_status)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // note accepted bytes and check accepted results
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                sb.note_byte(s_in_byte);
            if (m_valid && m_ready)
                sb.check_char(m_code_point, m_status);
        end
    end

    // result side back-pressure in random bursts, each followed by a ready cycle
    initial begin : result_sink
        int unsigned hold;
        hold = 0;
        m_ready <= 1'b0;
        @(posedge aclk);
        forever begin
            if (hold != 0) begin
                m_ready <= 1'b0;
                hold--;
            end else if (m_ready && stall_pct != 0 && $urandom_range(99, 0) < stall_pct) begin
                m_ready <= 1'b0;
                hold = $urandom_range(16, 1) - 1;
            end else begin
                m_ready <= 1'b1;
            end
            @(posedge aclk);
        end
    end

    // ends the run when no beat moves for too long
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb NOT OK");
        $finish;
    end

    // one byte beat, with an optional gap ahead of it
    task automatic send_byte(input logic [7:0] b);
        if (gap_pct != 0 && $urandom_range(99, 0) < gap_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(16, 1)) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_in_byte <= b;
        do @(posedge aclk); while (!s_ready);
        bytes_sent++;
    endtask

    // mostly well-formed sequences, with noise, nul breaks and cut-off tails
    task automatic send_random_run();
        int unsigned pick;
        int unsigned len;
        int unsigned i;
        logic [7:0]  lead;
        logic [7:0]  tail;
        pick = $urandom_range(99, 0);
        if (pick < 12) begin
            send_byte(8'($urandom_range(255, 0)));
            return;
        end
        pick = $urandom_range(99, 0);
        if (pick < 35)
            len = 1;
        else if (pick < 55)
            len = 2;
        else if (pick < 70)
            len = 3;
        else if (pick < 82)
            len = 4;
        else if (pick < 91)
            len = 5;
        else
            len = 6;
        case (len)
            1: lead = 8'($urandom_range(127, 0));
            2: lead = 8'($urandom_range(223, 192));
            3: lead = 8'($urandom_range(239, 224));
            4: lead = 8'($urandom_range(247, 240));
            5: lead = 8'($urandom_range(251, 248));
            default: lead = 8'($urandom_range(253, 252));
        endcase
        send_byte(lead);
        for (i = 1; i < len; i++) begin
            pick = $urandom_range(99, 0);
            if (pick < 3) begin
                send_byte(8'h00);
                return;
            end
            // cut short: the next lead lands as a continuation
            if (pick < 6)
                return;
            if (pick < 16)
                tail = 8'($urandom_range(255, 1));
            else
                tail = {2'b10, 6'($urandom_range(63, 0))};
            send_byte(tail);
        end
    endtask

    // reset, directed bytes, random runs, drain
    initial begin : stimulus
        int unsigned next_phase;
        bit          paused;
        aresetn    <= 1'b0;
        s_valid    <= 1'b0;
        s_in_byte  <= 8'h00;
        gap_pct    = 0;
        stall_pct  = 0;
        bytes_sent = 0;
        paused     = 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        gap_pct   = 10;
        stall_pct = 10;
        foreach (DIRECTED_BYTES[i])
            send_byte(DIRECTED_BYTES[i]);

        next_phase = bytes_sent;
        while (bytes_sent < RANDOM_BYTES) begin
            // new idle mix every phase, none near the end
            if (bytes_sent + CALM_TAIL >= RANDOM_BYTES) begin
                gap_pct   = 0;
                stall_pct = 0;
            end else if (bytes_sent >= next_phase) begin
                next_phase = bytes_sent + PHASE_LEN;
                case ($urandom_range(3, 0))
                    0: gap_pct = 0;
                    1: gap_pct = 5;
                    2: gap_pct = 20;
                    default: gap_pct = 50;
                endcase
                case ($urandom_range(3, 0))
                    0: stall_pct = 0;
                    1: stall_pct = 5;
                    2: stall_pct = 20;
                    default: stall_pct = 50;
                endcase
            end
            // hold the input until every owed character is out
            if (!paused && bytes_sent >= PAUSE_AT) begin
                paused = 1'b1;
                s_valid <= 1'b0;
                do @(posedge aclk); while (sb.pending_count() != 0);
            end
            send_random_run();
        end

        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.pending_count() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.fail_count == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
